// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL. Each check is clocked on clk and
// disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check that an expression holds at every clock edge.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(label, expr, msg)
`define ASSERT_IMPLY(label, ante, cons, msg)

`endif

`endif

// ===== rtl/dpw_pkg.sv =====
package dpw_pkg;

  // Image coordinate bits that take part in the back-projection.
  localparam int COORD_WIDTH = 12;

  localparam int PIX_W    = 12;
  localparam int DEPTH_W  = 16;
  localparam int COLOR_W  = 8;
  localparam int WORLD_W  = 32;
  localparam int PCOLOR_W = 24;

  // Register file.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 60;
  localparam int KPROJ_W     = 20;  // Q2.18 inverse-projection coefficient
  localparam int ROT_W       = 16;  // Q2.14 rotation entry
  localparam int SHIFT_W     = 20;  // Q16.4 translation component
  localparam int SCALE_W     = 24;  // unsigned Q4.20 scale
  localparam int KROW_W      = 3 * KPROJ_W;
  localparam int ROTROW_W    = 3 * ROT_W;
  localparam int SHIFTVEC_W  = 3 * SHIFT_W;

  localparam logic [ROTROW_W-1:0] ROT_X_RESET   = ROTROW_W'(48'h0000_0000_4000);
  localparam logic [ROTROW_W-1:0] ROT_Y_RESET   = ROTROW_W'(48'h0000_4000_0000);
  localparam logic [ROTROW_W-1:0] ROT_Z_RESET   = ROTROW_W'(48'h4000_0000_0000);
  localparam logic [SCALE_W-1:0]  SCALE_RESET   = SCALE_W'(24'h10_0000);

  // Fixed-point alignment steps.
  localparam int DXY_SHIFT   = 10;  // Q.18 -> Q.8 for the back-projected x and y
  localparam int DZ_SHIFT    = 8;   // depth -> Q.8
  localparam int SHIFT_ALIGN = 18;  // translation Q.4 -> Q.22
  localparam int ACC_SHIFT   = 6;   // Q.22 -> Q.16
  localparam int SCALE_FRAC  = 20;  // Q.36 -> Q.16
  localparam int LO_W        = 32;  // low part of the magnitude fed to the scale

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_INV_PROJ_FIRST  = 3'd0,
    REG_INV_PROJ_SECOND = 3'd1,
    REG_ROT_X           = 3'd2,
    REG_ROT_Y           = 3'd3,
    REG_ROT_Z           = 3'd4,
    REG_SHIFT_VECTOR    = 3'd5,
    REG_OUTPUT_SCALE    = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [PIX_W-1:0]          pixel_row;
    logic [PIX_W-1:0]          pixel_col;
    logic signed [DEPTH_W-1:0] depth;
    logic [COLOR_W-1:0]        red_in;
    logic [COLOR_W-1:0]        green_in;
    logic [COLOR_W-1:0]        blue_in;
  } pixel_in_t;

  typedef struct packed {
    logic signed [WORLD_W-1:0] world_x;
    logic signed [WORLD_W-1:0] world_y;
    logic signed [WORLD_W-1:0] world_z;
    logic [PCOLOR_W-1:0]       packed_color;
    logic                      point_valid;
  } world_point_t;

endpackage

// ===== rtl/depth_pixel_to_world_point.sv =====
// Depth pixel to world point: turns one depth pixel (row, column, signed depth,
// RGB bytes) into one colored world point. The pixel is back-projected through
// the two programmed rows of the inverse camera matrix (z is the depth itself),
// rotated, translated, multiplied by the output scale and saturated to signed
// Q16.16; the color comes out as red<<16 | green<<8 | blue. A depth of zero
// gives an all-zero point with point_valid low. The block takes one item per
// clock unless a full pipeline is stalled at the output; each result passes
// through the ten-stage arithmetic pipeline: four multiply levels (two for
// the back-projection, one for the rotation, one split level for the scale),
// the first two each followed by one add or rounding stage, the rotation by
// its sum stage and its rounded-magnitude stage, and the scale by its combine
// and round stage and its saturation stage. Each stage holds its item
// only while the one after it is full and stalled, so bubbles close up and the
// input keeps accepting items while a finished result waits at the output.
// Program the registers only while the pipeline is empty.
`include "assert_macros.svh"

module depth_pixel_to_world_point
  import dpw_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // input items
  input  logic                   in_valid,
  output logic                   in_ready,
  input  pixel_in_t              in_data,
  // result items
  output logic                   out_valid,
  input  logic                   out_ready,
  output world_point_t           out_data,
  // register writes
  input  logic                   cfg_wen,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int NUM_STAGES = 10;

  // Datapath widths, each derived from the ones above it.
  localparam int COL_W  = COORD_WIDTH + 1;             // coordinate as a signed value
  localparam int PK_W   = KPROJ_W + COL_W;             // k * coordinate
  localparam int RAY_W  = PK_W + 2;                    // sum of three terms
  localparam int PD_W   = DEPTH_W + RAY_W;             // depth * ray
  localparam int DX_W   = PD_W - DXY_SHIFT;            // camera point in Q.8
  localparam int RP_W   = ROT_W + DX_W;                // rotation * camera coordinate
  localparam int ACC_W  = RP_W + 2;                    // rotated sum plus translation
  localparam int MAG_W  = ACC_W - ACC_SHIFT;           // rounded magnitude in Q.16
  localparam int HI_W   = MAG_W - LO_W;
  localparam int PLO_W  = LO_W + SCALE_W;
  localparam int PHI_W  = HI_W + SCALE_W;
  localparam int FULL_W = PHI_W + LO_W + 1;
  localparam int R_W    = FULL_W - SCALE_FRAC;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [KROW_W-1:0]     inv_proj_first;
  logic [KROW_W-1:0]     inv_proj_second;
  logic [ROTROW_W-1:0]   rot_row [3];
  logic [SHIFTVEC_W-1:0] shift_vector;
  logic [SCALE_W-1:0]    output_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_proj_first  <= '0;
      inv_proj_second <= '0;
      rot_row[0]      <= ROT_X_RESET;
      rot_row[1]      <= ROT_Y_RESET;
      rot_row[2]      <= ROT_Z_RESET;
      shift_vector    <= '0;
      output_scale    <= SCALE_RESET;
    end else if (cfg_wen) begin
      // Drop writes to unknown indexes; keep only each register's own bits.
      unique case (cfg_index)
        REG_INV_PROJ_FIRST:  inv_proj_first  <= cfg_wdata[KROW_W-1:0];
        REG_INV_PROJ_SECOND: inv_proj_second <= cfg_wdata[KROW_W-1:0];
        REG_ROT_X:           rot_row[0]      <= cfg_wdata[ROTROW_W-1:0];
        REG_ROT_Y:           rot_row[1]      <= cfg_wdata[ROTROW_W-1:0];
        REG_ROT_Z:           rot_row[2]      <= cfg_wdata[ROTROW_W-1:0];
        REG_SHIFT_VECTOR:    shift_vector    <= cfg_wdata[SHIFTVEC_W-1:0];
        REG_OUTPUT_SCALE:    output_scale    <= cfg_wdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Split the packed registers into signed lanes, element 0 lowest.
  logic signed [KPROJ_W-1:0] k_proj [2][3];
  logic signed [ROT_W-1:0]   rot    [3][3];
  logic signed [SHIFT_W-1:0] shift_lane [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      k_proj[0][i]  = inv_proj_first[KPROJ_W*i +: KPROJ_W];
      k_proj[1][i]  = inv_proj_second[KPROJ_W*i +: KPROJ_W];
      shift_lane[i] = shift_vector[SHIFT_W*i +: SHIFT_W];
      for (int j = 0; j < 3; j++) begin
        rot[i][j] = rot_row[i][ROT_W*j +: ROT_W];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control: a stage loads when it is empty or its successor
  // moves on.
  // ---------------------------------------------------------------------------
  logic [NUM_STAGES-1:0] stage_valid;
  logic [NUM_STAGES-1:0] stage_en;

  always_comb begin
    stage_en[NUM_STAGES-1] = !stage_valid[NUM_STAGES-1] || out_ready;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      stage_en[i] = !stage_valid[i] || stage_en[i+1];
    end
  end

  assign in_ready  = stage_en[0];
  assign out_valid = stage_valid[NUM_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      if (stage_en[0]) begin
        stage_valid[0] <= in_valid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (stage_en[i]) begin
          stage_valid[i] <= stage_valid[i-1];
        end
      end
    end
  end

  // Color and the nonzero-depth flag ride alongside the arithmetic.
  logic [PCOLOR_W-1:0] pipe_color [NUM_STAGES];
  logic                pipe_pv    [NUM_STAGES];

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      pipe_pv[0]    <= |in_data.depth;
      pipe_color[0] <= (|in_data.depth) ?
                       {in_data.red_in, in_data.green_in, in_data.blue_in} : '0;
    end
    for (int i = 1; i < NUM_STAGES; i++) begin
      if (stage_en[i]) begin
        pipe_pv[i]    <= pipe_pv[i-1];
        pipe_color[i] <= pipe_color[i-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: coefficient times column and row
  // ---------------------------------------------------------------------------
  logic signed [COL_W-1:0]   col_s;
  logic signed [COL_W-1:0]   row_s;
  logic signed [PK_W-1:0]    s1_kc [2];
  logic signed [PK_W-1:0]    s1_kr [2];
  logic signed [DEPTH_W-1:0] s1_d;

  // Ignore coordinate bits above COORD_WIDTH.
  assign col_s = {1'b0, in_data.pixel_col[COORD_WIDTH-1:0]};
  assign row_s = {1'b0, in_data.pixel_row[COORD_WIDTH-1:0]};

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      for (int a = 0; a < 2; a++) begin
        s1_kc[a] <= k_proj[a][0] * col_s;
        s1_kr[a] <= k_proj[a][1] * row_s;
      end
      s1_d <= in_data.depth;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: ray direction in Q.18
  // ---------------------------------------------------------------------------
  logic signed [RAY_W-1:0]   s2_ray [2];
  logic signed [DEPTH_W-1:0] s2_d;

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      for (int a = 0; a < 2; a++) begin
        s2_ray[a] <= RAY_W'(s1_kc[a]) + RAY_W'(s1_kr[a]) + RAY_W'(k_proj[a][2]);
      end
      s2_d <= s1_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: depth times ray
  // ---------------------------------------------------------------------------
  logic signed [PD_W-1:0]    s3_prod [2];
  logic signed [DEPTH_W-1:0] s3_d;

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      for (int a = 0; a < 2; a++) begin
        s3_prod[a] <= s2_ray[a] * s2_d;
      end
      s3_d <= s2_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: round x and y to Q.8, half away from zero; z is the depth in Q.8
  // ---------------------------------------------------------------------------
  localparam int DXY_HALF = 1 << (DXY_SHIFT - 1);

  logic signed [PD_W-1:0] dxy_biased [2];
  logic signed [DX_W-1:0] s4_vec [3];

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      // A negative value takes one less so the arithmetic shift rounds away
      // from zero on a tie.
      dxy_biased[a] = s3_prod[a] + (s3_prod[a][PD_W-1] ? PD_W'(DXY_HALF - 1)
                                                        : PD_W'(DXY_HALF));
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[3]) begin
      for (int a = 0; a < 2; a++) begin
        s4_vec[a] <= DX_W'(dxy_biased[a] >>> DXY_SHIFT);
      end
      s4_vec[2] <= DX_W'(s3_d) <<< DZ_SHIFT;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: rotation products
  // ---------------------------------------------------------------------------
  logic signed [RP_W-1:0] s5_prod [3][3];

  always_ff @(posedge clk) begin
    if (stage_en[4]) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          s5_prod[r][c] <= rot[r][c] * s4_vec[c];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: rotated sum plus translation, Q.22
  // ---------------------------------------------------------------------------
  logic signed [ACC_W-1:0] shift_term [3];
  logic signed [ACC_W-1:0] s6_acc [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      shift_term[r] = ACC_W'(shift_lane[r]) <<< SHIFT_ALIGN;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[5]) begin
      for (int r = 0; r < 3; r++) begin
        s6_acc[r] <= ACC_W'(s5_prod[r][0]) + ACC_W'(s5_prod[r][1])
                   + ACC_W'(s5_prod[r][2]) + shift_term[r];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 7: sign and rounded magnitude in Q.16
  // ---------------------------------------------------------------------------
  localparam int ACC_HALF = 1 << (ACC_SHIFT - 1);

  logic [ACC_W-1:0] acc_abs_round [3];
  logic [MAG_W-1:0] s7_mag [3];
  logic             s7_neg [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      // For a negative sum ~acc + 1 is its magnitude; fold the +1 into the
      // rounding constant so one adder does both.
      acc_abs_round[r] = s6_acc[r][ACC_W-1] ?
                         (~s6_acc[r]) + ACC_W'(ACC_HALF + 1) :
                         s6_acc[r] + ACC_W'(ACC_HALF);
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[6]) begin
      for (int r = 0; r < 3; r++) begin
        s7_mag[r] <= acc_abs_round[r][ACC_W-1:ACC_SHIFT];
        s7_neg[r] <= s6_acc[r][ACC_W-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 8: magnitude times scale, split into high and low partial products
  // ---------------------------------------------------------------------------
  logic [PLO_W-1:0] s8_plo [3];
  logic [PHI_W-1:0] s8_phi [3];
  logic             s8_neg [3];

  always_ff @(posedge clk) begin
    if (stage_en[7]) begin
      for (int r = 0; r < 3; r++) begin
        s8_plo[r] <= s7_mag[r][LO_W-1:0] * output_scale;
        s8_phi[r] <= s7_mag[r][MAG_W-1:LO_W] * output_scale;
        s8_neg[r] <= s7_neg[r];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 9: combine the partial products and round Q.36 to Q.16
  // ---------------------------------------------------------------------------
  localparam int SCALE_HALF = 1 << (SCALE_FRAC - 1);

  logic [FULL_W-1:0] scaled_full [3];
  logic [R_W-1:0]    s9_mag [3];
  logic              s9_neg [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      scaled_full[r] = {1'b0, s8_phi[r], {LO_W{1'b0}}} + FULL_W'(s8_plo[r])
                     + FULL_W'(SCALE_HALF);
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[8]) begin
      for (int r = 0; r < 3; r++) begin
        s9_mag[r] <= scaled_full[r][FULL_W-1:SCALE_FRAC];
        s9_neg[r] <= s8_neg[r];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 10: saturate, restore the sign, blank empty points; output register
  // ---------------------------------------------------------------------------
  localparam logic [WORLD_W-1:0] WORLD_MAX = {1'b0, {(WORLD_W-1){1'b1}}};
  localparam logic [WORLD_W-1:0] WORLD_MIN = {1'b1, {(WORLD_W-1){1'b0}}};

  logic              pos_over [3];
  logic              neg_over [3];
  logic [WORLD_W-1:0] world_sat [3];
  logic [WORLD_W-1:0] s10_world [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      pos_over[r] = |s9_mag[r][R_W-1:WORLD_W-1];
      neg_over[r] = (|s9_mag[r][R_W-1:WORLD_W])
                 || (s9_mag[r][WORLD_W-1] && (|s9_mag[r][WORLD_W-2:0]));
      if (s9_neg[r]) begin
        world_sat[r] = neg_over[r] ? WORLD_MIN : WORLD_W'(0) - s9_mag[r][WORLD_W-1:0];
      end else begin
        world_sat[r] = pos_over[r] ? WORLD_MAX : s9_mag[r][WORLD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[9]) begin
      for (int r = 0; r < 3; r++) begin
        s10_world[r] <= pipe_pv[8] ? world_sat[r] : '0;
      end
    end
  end

  always_comb begin
    out_data.world_x      = s10_world[0];
    out_data.world_y      = s10_world[1];
    out_data.world_z      = s10_world[2];
    out_data.packed_color = pipe_color[NUM_STAGES-1];
    out_data.point_valid  = pipe_pv[NUM_STAGES-1];
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // The input stalls only when every stage holds an item.
  `ASSERT_IMPLY(a_stall_only_when_full, !in_ready, &stage_valid, "input stalled with a bubble in the pipeline")
  // An empty point leaves with all-zero coordinates and color.
  `ASSERT_IMPLY(a_empty_point_zero, out_valid && !out_data.point_valid, (out_data.world_x == 0) && (out_data.world_y == 0) && (out_data.world_z == 0) && (out_data.packed_color == 0), "empty point carries nonzero data")

endmodule
